### hdl/lcar_pkg.sv
`timescale 1ns / 1ps

package lcar_pkg;

   // Field widths of the request, response and register beats
   localparam int RAW_W    = 24;
   localparam int KW_W     = 24;
   localparam int GAIN_W   = 2;
   localparam int WEIGHT_W = 40;

   // Configuration port
   localparam int CSR_DATA_W = 24;
   localparam int CSR_IDX_W  = 4;

   typedef logic [CSR_IDX_W-1:0] csr_index_type;

   localparam csr_index_type CSR_REF_MASS    = csr_index_type'(0);
   localparam csr_index_type CSR_GAIN_PULSES = csr_index_type'(1);

   // Register reset values
   localparam logic [KW_W-1:0]   REF_MASS_RST    = KW_W'(256);
   localparam logic [GAIN_W-1:0] GAIN_PULSES_RST = GAIN_W'(1);

   // Weight saturation value
   localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = '1;

endpackage

### hdl/load_cell_adc_reader.sv
`timescale 1ns / 1ps

// Two-wire load cell converter reader.
// Each request beat is one time-base tick carrying the sampled data pin;
// each tick yields exactly one response beat with the clock pin level for
// that tick. While idle the clock stays low until the data pin reads low,
// then DATA_BITS pulses (high tick, low tick) shift the sample in MSB
// first, followed by gain_pulses extra pulses (zero acts as one). The
// closing tick reports the reading in offset binary and its weight =
// ref_mass * raw / calibration_raw; the first reading after reset becomes
// the calibration value. An ordinary tick answers in the cycle after
// acceptance. The closing tick runs a bit-serial multiply, then a
// restoring divide, one bit per cycle, and answers with the saturated
// quotient; a zero calibration value skips both, like an ordinary tick.
// One tick is in flight at a time: a new beat is taken once the sequencer is
// idle and the response register is empty or being drained this cycle.
// When the receiver stalls, the response holds and no tick is accepted.
// Reset returns the interface to idle, clears the calibration and loads
// a reference mass of 256 (1.0) and gain_pulses = 1.
module load_cell_adc_reader #(
   parameter int DATA_BITS = 24
) (
   input  logic                                clock,
   input  logic                                reset,
   // tick input
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_data_pin,
   // result output
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_clock_pin,
   output logic                                rsp_reading_valid,
   output logic                                rsp_is_calibration,
   output logic [lcar_pkg::RAW_W-1:0]          rsp_raw_reading,
   output logic [lcar_pkg::WEIGHT_W-1:0]       rsp_weight,
   output logic                                rsp_divide_error,
   // configuration
   input  logic                                csr_we,
   input  lcar_pkg::csr_index_type             csr_index,
   input  logic [lcar_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int PW   = lcar_pkg::KW_W + DATA_BITS;                 // product width
   localparam int QW   = (PW > lcar_pkg::WEIGHT_W) ? PW : lcar_pkg::WEIGHT_W;
   localparam int RW   = (DATA_BITS > lcar_pkg::RAW_W) ? DATA_BITS : lcar_pkg::RAW_W;
   localparam int PCW  = $clog2(DATA_BITS + 4);
   localparam int CNTW = $clog2(PW + 1);

   // converter interface phases
   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_HIGH = 2'd1;
   localparam logic [1:0] PH_LOW  = 2'd2;
   localparam logic [1:0] PH_DONE = 2'd3;

   // arithmetic sequencer states
   localparam logic [1:0] SQ_IDLE = 2'd0;
   localparam logic [1:0] SQ_MUL  = 2'd1;
   localparam logic [1:0] SQ_DIV  = 2'd2;
   localparam logic [1:0] SQ_OUT  = 2'd3;

   logic [lcar_pkg::KW_W-1:0]    kw_ff, kw_in;
   logic [lcar_pkg::GAIN_W-1:0]  gain_ff, gain_in;
   logic [1:0]                   phase_ff, phase_in;
   logic [PCW-1:0]               pulse_ff, pulse_in;
   logic [DATA_BITS-1:0]         shift_ff, shift_in;
   logic [DATA_BITS-1:0]         cal_ff, cal_in;
   logic                         calibrated_ff, calibrated_in;
   logic [1:0]                   sq_ff, sq_in;
   logic [CNTW-1:0]              cnt_ff, cnt_in;
   logic [DATA_BITS-1:0]         mcand_ff, mcand_in;
   logic [PW-1:0]                acc_ff, acc_in;
   logic [DATA_BITS-1:0]         rem_ff, rem_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         clk_pin_ff, clk_pin_in;
   logic                         rd_valid_ff, rd_valid_in;
   logic                         is_cal_ff, is_cal_in;
   logic [lcar_pkg::RAW_W-1:0]   raw_out_ff, raw_out_in;
   logic [lcar_pkg::WEIGHT_W-1:0] weight_ff, weight_in;
   logic                         derr_ff, derr_in;

   logic                         accept;
   logic [lcar_pkg::GAIN_W-1:0]  gain_eff;
   logic [PCW-1:0]               pulse_next;
   logic [PCW-1:0]               pulse_limit;
   logic [DATA_BITS-1:0]         raw;
   logic [RW-1:0]                raw_ext;
   logic [DATA_BITS-1:0]         divisor;
   logic [DATA_BITS:0]           rem_sh;
   logic [DATA_BITS:0]           rem_sub;
   logic                         q_bit;
   logic [QW-1:0]                quot_ext;

   assign req_ready = (sq_ff == SQ_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;

   assign gain_eff    = (gain_ff == '0) ? lcar_pkg::GAIN_W'(1) : gain_ff;
   assign pulse_next  = pulse_ff + PCW'(1);
   assign pulse_limit = PCW'(DATA_BITS) + PCW'(gain_eff);

   // offset binary: flip the sign bit
   assign raw     = shift_ff ^ {1'b1, {(DATA_BITS-1){1'b0}}};
   assign raw_ext = RW'(raw);
   assign divisor = calibrated_ff ? cal_ff : raw;

   // one restoring divide step
   assign rem_sh  = {rem_ff, acc_ff[PW-1]};
   assign q_bit   = (rem_sh >= {1'b0, cal_ff});
   assign rem_sub = rem_sh - {1'b0, cal_ff};

   assign quot_ext = QW'(acc_ff);

   always_comb begin
      kw_in         = kw_ff;
      gain_in       = gain_ff;
      phase_in      = phase_ff;
      pulse_in      = pulse_ff;
      shift_in      = shift_ff;
      cal_in        = cal_ff;
      calibrated_in = calibrated_ff;
      sq_in         = sq_ff;
      cnt_in        = cnt_ff;
      mcand_in      = mcand_ff;
      acc_in        = acc_ff;
      rem_in        = rem_ff;
      rsp_valid_in  = rsp_valid_ff;
      clk_pin_in    = clk_pin_ff;
      rd_valid_in   = rd_valid_ff;
      is_cal_in     = is_cal_ff;
      raw_out_in    = raw_out_ff;
      weight_in     = weight_ff;
      derr_in       = derr_ff;

      // register writes
      if (csr_we) begin
         if (csr_index == lcar_pkg::CSR_REF_MASS) begin
            kw_in = csr_wdata[lcar_pkg::KW_W-1:0];
         end
         if (csr_index == lcar_pkg::CSR_GAIN_PULSES) begin
            gain_in = csr_wdata[lcar_pkg::GAIN_W-1:0];
         end
      end

      // drop the response once taken
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      // advance the converter interface by one tick
      if (accept) begin
         clk_pin_in  = 1'b0;
         rd_valid_in = 1'b0;
         is_cal_in   = 1'b0;
         raw_out_in  = '0;
         weight_in   = '0;
         derr_in     = 1'b0;
         rsp_valid_in = 1'b1;
         unique case (phase_ff)
            PH_HIGH: begin
               clk_pin_in = 1'b1;
               if (pulse_ff >= PCW'(1) && pulse_ff <= PCW'(DATA_BITS)) begin
                  shift_in = {shift_ff[DATA_BITS-2:0], req_data_pin};
               end
               phase_in = PH_LOW;
            end
            PH_LOW: begin
               pulse_in = pulse_next;
               phase_in = (pulse_next >= pulse_limit) ? PH_DONE : PH_HIGH;
            end
            PH_DONE: begin
               rd_valid_in = 1'b1;
               raw_out_in  = raw_ext[lcar_pkg::RAW_W-1:0];
               if (!calibrated_ff) begin
                  cal_in        = raw;
                  calibrated_in = 1'b1;
                  is_cal_in     = 1'b1;
               end
               if (divisor == '0) begin
                  weight_in = lcar_pkg::WEIGHT_MAX;
                  derr_in   = 1'b1;
               end else begin
                  // hold the beat until the weight is ready
                  rsp_valid_in = 1'b0;
                  mcand_in     = raw;
                  acc_in       = '0;
                  cnt_in       = CNTW'(DATA_BITS);
                  sq_in        = SQ_MUL;
               end
               phase_in = PH_IDLE;
               pulse_in = '0;
               shift_in = '0;
            end
            PH_IDLE: begin
               if (!req_data_pin) begin
                  phase_in = PH_HIGH;
                  pulse_in = '0;
                  shift_in = '0;
               end
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end

      // bit-serial multiply then restoring divide
      unique case (sq_ff)
         SQ_MUL: begin
            acc_in   = {acc_ff[PW-2:0], 1'b0} +
                       (mcand_ff[DATA_BITS-1] ? PW'(kw_ff) : PW'(0));
            mcand_in = {mcand_ff[DATA_BITS-2:0], 1'b0};
            cnt_in   = cnt_ff - CNTW'(1);
            if (cnt_ff == CNTW'(1)) begin
               cnt_in = CNTW'(PW);
               rem_in = '0;
               sq_in  = SQ_DIV;
            end
         end
         SQ_DIV: begin
            acc_in = {acc_ff[PW-2:0], q_bit};
            rem_in = q_bit ? rem_sub[DATA_BITS-1:0] : rem_sh[DATA_BITS-1:0];
            cnt_in = cnt_ff - CNTW'(1);
            if (cnt_ff == CNTW'(1)) begin
               sq_in = SQ_OUT;
            end
         end
         SQ_OUT: begin
            // saturate the quotient into the weight field
            if (quot_ext > QW'(lcar_pkg::WEIGHT_MAX)) begin
               weight_in = lcar_pkg::WEIGHT_MAX;
            end else begin
               weight_in = quot_ext[lcar_pkg::WEIGHT_W-1:0];
            end
            rsp_valid_in = 1'b1;
            sq_in        = SQ_IDLE;
         end
         SQ_IDLE: begin
         end
         default: begin
            sq_in = SQ_IDLE;
         end
      endcase

      // last divide step lands in acc; keep it for the output state
      if (sq_ff == SQ_OUT) begin
         acc_in = acc_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         kw_ff         <= lcar_pkg::REF_MASS_RST;
         gain_ff       <= lcar_pkg::GAIN_PULSES_RST;
         phase_ff      <= PH_IDLE;
         pulse_ff      <= '0;
         shift_ff      <= '0;
         cal_ff        <= '0;
         calibrated_ff <= 1'b0;
         sq_ff         <= SQ_IDLE;
         rsp_valid_ff  <= 1'b0;
      end else begin
         kw_ff         <= kw_in;
         gain_ff       <= gain_in;
         phase_ff      <= phase_in;
         pulse_ff      <= pulse_in;
         shift_ff      <= shift_in;
         cal_ff        <= cal_in;
         calibrated_ff <= calibrated_in;
         sq_ff         <= sq_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // datapath and response payload
   always_ff @(posedge clock) begin
      cnt_ff      <= cnt_in;
      mcand_ff    <= mcand_in;
      acc_ff      <= acc_in;
      rem_ff      <= rem_in;
      clk_pin_ff  <= clk_pin_in;
      rd_valid_ff <= rd_valid_in;
      is_cal_ff   <= is_cal_in;
      raw_out_ff  <= raw_out_in;
      weight_ff   <= weight_in;
      derr_ff     <= derr_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_clock_pin      = clk_pin_ff;
   assign rsp_reading_valid  = rd_valid_ff;
   assign rsp_is_calibration = is_cal_ff;
   assign rsp_raw_reading    = raw_out_ff;
   assign rsp_weight         = weight_ff;
   assign rsp_divide_error   = derr_ff;

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps

module testbench;

   localparam int DATA_BITS    = 24;
   localparam int CYCLE_LIMIT  = 500000;
   localparam int DRAIN_CYCLES = 2 * DATA_BITS + 60;
   localparam int RANDOM_TICKS = 860;

   // Converter sequencer phases
   typedef enum logic [1:0] {SEQ_IDLE, SEQ_HIGH, SEQ_LOW, SEQ_DONE} seq_phase_type;

   // One response beat
   typedef struct packed {
      logic                          clock_pin;
      logic                          reading_valid;
      logic                          is_calibration;
      logic [lcar_pkg::RAW_W-1:0]    raw_reading;
      logic [lcar_pkg::WEIGHT_W-1:0] weight;
      logic                          divide_error;
   } tick_beat_type;

   // Tracks the converter protocol and the weight math, one tick at a time
   class reading_board_type;
      logic [lcar_pkg::KW_W-1:0]   ref_mass;
      logic [lcar_pkg::GAIN_W-1:0] gain_pulses;
      seq_phase_type               phase;
      int unsigned                 pulses;
      logic [23:0]                 shift_reg;
      logic [23:0]                 cal_raw;
      bit                          have_cal;
      tick_beat_type               due_beats[$];
      int unsigned                 ticks;
      int unsigned                 readings;
      int unsigned                 errors;

      function new();
         ref_mass     = lcar_pkg::REF_MASS_RST;
         gain_pulses  = lcar_pkg::GAIN_PULSES_RST;
         phase        = SEQ_IDLE;
         pulses       = 0;
         shift_reg    = '0;
         cal_raw      = '0;
         have_cal     = 1'b0;
         ticks        = 0;
         readings     = 0;
         errors       = 0;
      endfunction

      function int unsigned eff_gain();
         return (gain_pulses == 0) ? 1 : gain_pulses;
      endfunction

      function bit at_rest();
         return phase == SEQ_IDLE;
      endfunction

      function int unsigned pending();
         return due_beats.size();
      endfunction

      function void set_reg(lcar_pkg::csr_index_type idx,
                            logic [lcar_pkg::CSR_DATA_W-1:0] val);
         case (idx)
            lcar_pkg::CSR_REF_MASS:    ref_mass    = val[lcar_pkg::KW_W-1:0];
            lcar_pkg::CSR_GAIN_PULSES: gain_pulses = val[lcar_pkg::GAIN_W-1:0];
            default: ;
         endcase
      endfunction

      // Advance the sequencer by one accepted tick and queue its beat
      function void log_tick(logic pin);
         tick_beat_type r;
         logic [23:0]   raw;
         logic [47:0]   prod;
         logic [47:0]   quo;
         r = '0;
         ticks++;
         case (phase)
            SEQ_HIGH: begin
               r.clock_pin = 1'b1;
               if (pulses >= 1 && pulses <= DATA_BITS)
                  shift_reg = {shift_reg[22:0], pin};
               phase = SEQ_LOW;
            end
            SEQ_LOW: begin
               pulses++;
               if (pulses >= DATA_BITS + eff_gain())
                  phase = SEQ_DONE;
               else
                  phase = SEQ_HIGH;
            end
            SEQ_DONE: begin
               raw = shift_reg ^ 24'h800000;
               r.reading_valid = 1'b1;
               if (!have_cal) begin
                  cal_raw  = raw;
                  have_cal = 1'b1;
                  r.is_calibration = 1'b1;
               end
               r.raw_reading = raw;
               if (cal_raw == 0) begin
                  r.weight       = lcar_pkg::WEIGHT_MAX;
                  r.divide_error = 1'b1;
               end else begin
                  prod = {24'b0, ref_mass} * {24'b0, raw};
                  quo  = prod / {24'b0, cal_raw};
                  r.weight = (quo > {8'b0, lcar_pkg::WEIGHT_MAX}) ?
                             lcar_pkg::WEIGHT_MAX : quo[lcar_pkg::WEIGHT_W-1:0];
               end
               phase     = SEQ_IDLE;
               pulses    = 0;
               shift_reg = '0;
               readings++;
            end
            default: begin
               if (pin == 1'b0) begin
                  phase     = SEQ_HIGH;
                  pulses    = 0;
                  shift_reg = '0;
               end
            end
         endcase
         due_beats.push_back(r);
      endfunction

      function void cmp_field(string name, logic [lcar_pkg::WEIGHT_W-1:0] exp_v,
                              logic [lcar_pkg::WEIGHT_W-1:0] act_v);
         if (act_v !== exp_v) begin
            errors++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
         end
      endfunction

      // Compare one response beat with the oldest outstanding tick
      function void check_beat(tick_beat_type act);
         tick_beat_type exp_b;
         if (due_beats.size() == 0) begin
            errors++;
            $display("%0t: response beat with no tick outstanding, expected none, actual %h",
                     $time, act);
            return;
         end
         exp_b = due_beats.pop_front();
         cmp_field("clock_pin", exp_b.clock_pin, act.clock_pin);
         cmp_field("reading_valid", exp_b.reading_valid, act.reading_valid);
         cmp_field("is_calibration", exp_b.is_calibration, act.is_calibration);
         cmp_field("raw_reading", exp_b.raw_reading, act.raw_reading);
         cmp_field("weight", exp_b.weight, act.weight);
         cmp_field("divide_error", exp_b.divide_error, act.divide_error);
      endfunction
   endclass

   logic                            clock;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_ready;
   logic                            req_data_pin = 1'b1;
   logic                            rsp_valid;
   logic                            rsp_ready = 1'b0;
   logic                            rsp_clock_pin;
   logic                            rsp_reading_valid;
   logic                            rsp_is_calibration;
   logic [lcar_pkg::RAW_W-1:0]      rsp_raw_reading;
   logic [lcar_pkg::WEIGHT_W-1:0]   rsp_weight;
   logic                            rsp_divide_error;
   logic                            csr_we = 1'b0;
   lcar_pkg::csr_index_type         csr_index = lcar_pkg::CSR_REF_MASS;
   logic [lcar_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   reading_board_type board = new();
   bit                gaps_on = 1'b1;
   int unsigned       cycles = 0;
   int unsigned       stall_left = 0;

   load_cell_adc_reader #(
      .DATA_BITS(DATA_BITS)
   ) i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_data_pin       (req_data_pin),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_clock_pin      (rsp_clock_pin),
      .rsp_reading_valid  (rsp_reading_valid),
      .rsp_is_calibration (rsp_is_calibration),
      .rsp_raw_reading    (rsp_raw_reading),
      .rsp_weight         (rsp_weight),
      .rsp_divide_error   (rsp_divide_error),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Stop a hung run
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Stall the receiver in random bursts
   always @(posedge clock) begin
      if (!gaps_on) begin
         rsp_ready  <= 1'b1;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 7) == 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= $urandom_range(1, 12) - 1;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Check every accepted response beat
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         board.check_beat({rsp_clock_pin, rsp_reading_valid, rsp_is_calibration,
                           rsp_raw_reading, rsp_weight, rsp_divide_error});
   end

   // Offer one tick, optionally after a gap, and log it once accepted
   task automatic send_tick(input logic pin);
      int unsigned gap;
      if (gaps_on && $urandom_range(0, 7) == 0) begin
         gap = $urandom_range(1, 12);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_data_pin <= pin;
      do @(posedge clock); while (req_ready !== 1'b1);
      board.log_tick(pin);
   endtask

   // Hold the sender until every outstanding beat has come back
   task automatic drain_all();
      req_valid <= 1'b0;
      do @(posedge clock); while (board.pending() != 0);
   endtask

   task automatic write_reg(input lcar_pkg::csr_index_type idx,
                            input logic [lcar_pkg::CSR_DATA_W-1:0] val);
      drain_all();
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      board.set_reg(idx, val);
      @(posedge clock);
   endtask

   task automatic write_gain(input logic [1:0] g);
      write_reg(lcar_pkg::CSR_GAIN_PULSES,
                {lcar_pkg::CSR_DATA_W'($urandom_range(0, 32'h3fffff)) << 2} | g);
   endtask

   // Clock out any partial conversion until the sequencer is idle
   task automatic settle_idle();
      while (!board.at_rest()) send_tick(1'($urandom_range(0, 1)));
   endtask

   // One full conversion: start, data bits MSB first, extra pulses, report
   task automatic run_conversion(input logic [23:0] word);
      int unsigned ticks_left;
      settle_idle();
      repeat ($urandom_range(0, 3)) send_tick(1'b1);
      send_tick(1'b0);
      ticks_left = 2 * (DATA_BITS + board.eff_gain()) + 1;
      for (int t = 0; t < ticks_left; t++) begin
         if (t >= 2 && t <= 2 * DATA_BITS && t % 2 == 0)
            send_tick(word[DATA_BITS - t / 2]);
         else
            send_tick(1'($urandom_range(0, 1)));
      end
   endtask

   task automatic noise_burst();
      repeat ($urandom_range(3, 40)) send_tick(1'($urandom_range(0, 1)));
   endtask

   function automatic logic [23:0] pick_word();
      case ($urandom_range(0, 11))
         0:       return 24'h000000;
         1:       return 24'hffffff;
         2:       return 24'h800000;
         3:       return 24'h7fffff;
         default: return 24'($urandom_range(0, 32'hffffff));
      endcase
   endfunction

   function automatic logic [23:0] pick_weight();
      case ($urandom_range(0, 7))
         0:       return 24'h000000;
         1:       return 24'hffffff;
         2:       return 24'h000100;
         3, 4:    return 24'($urandom_range(0, 32'h3ff));
         default: return 24'($urandom_range(0, 32'hffffff));
      endcase
   endfunction

   initial begin
      int unsigned tick_base;
      logic [23:0] cal_word;

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Calibrate on a small raw value so that large products can saturate
      cal_word = 24'($urandom_range(32'h40, 32'h3ff)) ^ 24'h800000;
      run_conversion(cal_word);

      // Extremes of the raw reading, zero raw included
      run_conversion(24'h000000);
      run_conversion(24'hffffff);
      run_conversion(24'h800000);
      run_conversion(24'h7fffff);

      // Largest reference mass on the largest raw value, then zero weight
      write_reg(lcar_pkg::CSR_REF_MASS, 24'hffffff);
      run_conversion(24'h7fffff);
      write_reg(lcar_pkg::CSR_REF_MASS, 24'h000000);
      run_conversion(pick_word());
      write_reg(lcar_pkg::CSR_REF_MASS, 24'h000300);

      // Gains two and zero, with zero standing in for one
      write_gain(2'd2);
      run_conversion(pick_word());
      write_gain(2'd0);
      run_conversion(pick_word());

      // Lower the gain while the extra pulses are under way
      write_gain(2'd3);
      settle_idle();
      send_tick(1'b0);
      for (int t = 0; t < 2 * (DATA_BITS + 1) + 1; t++) send_tick(1'($urandom_range(0, 1)));
      write_gain(2'd1);
      settle_idle();

      // Broken sequence, then a full pause
      noise_burst();
      drain_all();

      // Random phases of settings, conversions and noise
      tick_base = board.ticks;
      while (board.ticks - tick_base < RANDOM_TICKS) begin
         if (board.ticks - tick_base > RANDOM_TICKS * 85 / 100) begin
            gaps_on = 1'b0;
         end else if ($urandom_range(0, 4) == 0) begin
            if ($urandom_range(0, 1) == 0)
               write_reg(lcar_pkg::CSR_REF_MASS, pick_weight());
            if ($urandom_range(0, 1) == 0)
               write_gain(($urandom_range(0, 7) == 0) ? 2'd0 : 2'($urandom_range(1, 3)));
            gaps_on = ($urandom_range(0, 3) != 0);
         end
         if ($urandom_range(0, 19) == 0)
            drain_all();
         if ($urandom_range(0, 6) == 0)
            noise_burst();
         else
            run_conversion(pick_word());
      end

      // Drain, then let the block sit for a while
      drain_all();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.errors == 0 && board.pending() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

### load_cell_adc_reader.f
hdl/lcar_pkg.sv
hdl/load_cell_adc_reader.sv
bench/testbench.sv
